// ===== rtl/core/gsam_pkg.sv =====
// shared types, constants and helpers for the gain scaled audio mixer
`default_nettype none

package gsam_pkg;

  localparam int NumSlots = 4;
  localparam int CHANNELS = 4;

  localparam int PcmW    = 16;
  localparam int GainW   = 15;
  localparam int ProdW   = 32;
  localparam int QuotW   = 17;
  localparam int ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CntW    = ChIdxW + 1;
  localparam int SumW    = QuotW + ChIdxW;
  localparam int CfgIdxW = 3;

  localparam int GainUnity = 32'h7fff;
  localparam int SumLimit  = 32'h7fff;

  localparam logic [GainW-1:0] GainReset = GainW'(GainUnity);
  localparam logic signed [SumW-1:0] SumHi = SumW'(SumLimit);
  localparam logic signed [SumW-1:0] SumLo = -SumW'(SumLimit);

  // register index of the first gain register, one register per channel
  localparam logic [CfgIdxW-1:0] CfgGainBase = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGainEnd  = CfgIdxW'(CHANNELS);

  typedef logic [CHANNELS-1:0][GainW-1:0] gsam_gains_t;

  typedef struct packed {
    logic [CHANNELS-1:0][ProdW-1:0] prod;
    logic                           multi;
  } gsam_scaled_t;

  // floor(x / 32767) for x below 2^30, via x = q0 * 32767 + (q0 + low bits)
  function automatic logic [QuotW-2:0] div_unity(input logic [29:0] x);
    logic [14:0]      q0;
    logic [16:0]      r0;
    logic [QuotW-2:0] q;
    q0 = x[29:15];
    r0 = {2'b00, x[14:0]} + {2'b00, q0};
    q  = {1'b0, q0};
    if (r0 >= 17'(2 * GainUnity)) begin
      q = q + 16'd2;
    end else if (r0 >= 17'(GainUnity)) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gsam_gain_regs.sv =====
// per-channel gain registers written through the configuration port
`default_nettype none

module gsam_gain_regs import gsam_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [GainW-1:0]   cfg_data_i,
  output gsam_gains_t             gains_o
);

  gsam_gains_t        gain_q, gain_d;
  logic [CfgIdxW-1:0] slot;

  assign cfg_ready_o = 1'b1;
  assign slot        = cfg_index_i - CfgGainBase;

  always_comb begin
    gain_d = gain_q;
    if (cfg_valid_i && cfg_index_i >= CfgGainBase && cfg_index_i < CfgGainEnd) begin
      gain_d[slot[ChIdxW-1:0]] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= {CHANNELS{GainReset}};
    end else begin
      gain_q <= gain_d;
    end
  end

  assign gains_o = gain_q;

endmodule

`default_nettype wire

// ===== rtl/core/gsam_scale_stage.sv =====
// input register: per-channel sample times gain and active channel count
`default_nettype none

module gsam_scale_stage import gsam_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [NumSlots*PcmW-1:0] pcm_i,
  input  wire logic [NumSlots-1:0]      has_i,
  input  wire logic [NumSlots-1:0]      live_i,
  input  wire gsam_gains_t              gains_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output gsam_scaled_t                  out_data_o
);

  logic         valid_q, valid_d;
  gsam_scaled_t data_q, data_d;
  logic [CntW-1:0] live_cnt;
  logic         load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    logic signed [ProdW-1:0] prod;
    assign prod = ProdW'($signed(pcm_i[ch*PcmW +: PcmW])) *
                  ProdW'($signed({1'b0, gains_i[ch]}));
    assign data_d.prod[ch] = (live_i[ch] && has_i[ch]) ? prod : '0;
  end

  always_comb begin
    live_cnt = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      live_cnt = live_cnt + CntW'(live_i[ch]);
    end
  end

  assign data_d.multi = (live_cnt >= CntW'(2));

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/gsam_mix_stage.sv =====
// result register: divide by unity gain, sum and clamp
`default_nettype none

module gsam_mix_stage import gsam_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gsam_scaled_t    in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [PcmW-1:0]      out_data_o
);

  logic                   valid_q, valid_d;
  logic [PcmW-1:0]        mixed_q, mixed_d;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] contrib [CHANNELS];
  logic                   load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    logic signed [ProdW-1:0] prod;
    logic [ProdW-1:0]        mag;
    logic signed [QuotW-1:0] quot;
    assign prod = $signed(in_data_i.prod[ch]);
    assign mag  = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
    // truncate toward zero: divide the magnitude, then restore the sign
    assign quot = $signed({1'b0, div_unity(mag[29:0])});
    assign contrib[ch] = prod[ProdW-1] ? SumW'(-quot) : SumW'(quot);
  end

  always_comb begin
    sum = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum = sum + contrib[ch];
    end
  end

  always_comb begin
    mixed_d = sum[PcmW-1:0];
    if (in_data_i.multi) begin
      if (sum > SumHi) begin
        mixed_d = SumHi[PcmW-1:0];
      end else if (sum < SumLo) begin
        mixed_d = SumLo[PcmW-1:0];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mixed_q <= mixed_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = mixed_q;

  a_multi_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_data_i.multi) |=> (mixed_q != 16'h8000))
    else $error("clamped mix reached -32768");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_data_i.prod == '0) |=> (mixed_q == '0))
    else $error("silent item gave nonzero mix");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("accepted request did not produce a result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(mixed_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/core/gain_scaled_audio_mixer.sv =====
// top level of the four channel pcm mixer with per-channel gain
`default_nettype none

// Mixes one 16-bit sample per channel into one output sample. A live channel
// adds sample*gain/32767 (truncated toward zero) when its has flag is set,
// else zero; with two or more live channels the sum is clamped to +/-32767,
// a single live channel passes unclamped, and no live channel gives zero.
// One request is taken every cycle unless the output stalls; each accepted
// request passes through the product register, then the result register.
// Gains are sampled when a request is accepted and reset to
// 32767 (unity); writes to unknown register indexes are ignored.
module gain_scaled_audio_mixer import gsam_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_tvalid_i,
  output logic                          s_tready_o,
  // pcm_ch0, pcm_ch1, pcm_ch2, pcm_ch3
  input  wire logic [NumSlots*PcmW-1:0] s_tdata_i,
  // has_ch0, has_ch1, has_ch2, has_ch3, live_ch0, live_ch1, live_ch2, live_ch3
  input  wire logic [2*NumSlots-1:0]    s_tuser_i,
  output logic                          m_tvalid_o,
  input  wire logic                     m_tready_i,
  // mixed_pcm
  output logic [PcmW-1:0]               m_tdata_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [GainW-1:0]         cfg_data_i
);

  gsam_gains_t  gains;
  gsam_scaled_t scaled;
  logic         scaled_valid;
  logic         scaled_ready;

  gsam_gain_regs u_gain_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gains_o     (gains)
  );

  gsam_scale_stage u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .pcm_i       (s_tdata_i),
    .has_i       (s_tuser_i[NumSlots-1:0]),
    .live_i      (s_tuser_i[2*NumSlots-1:NumSlots]),
    .gains_i     (gains),
    .out_valid_o (scaled_valid),
    .out_ready_i (scaled_ready),
    .out_data_o  (scaled)
  );

  gsam_mix_stage u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scaled_valid),
    .in_ready_o  (scaled_ready),
    .in_data_i   (scaled),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_data_o  (m_tdata_o)
  );

endmodule

`default_nettype wire
